// ===== design/sfau_pkg.sv =====
// Package for the single-precision arithmetic unit: opcodes and constants.
// No dependencies.
`timescale 1ns / 1ps
package sfau_pkg;
    localparam int MANT_W = 24;
    localparam int EXP_W  = 8;
    localparam logic [9:0] EXP_BIAS = 10'd127;
    localparam logic [30:0] MAX_FINITE = 31'h7F7FFFFF;
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;
endpackage

// ===== design/sfau_core.sv =====
// Sequential datapath: bit-serial multiply, restoring divide, serial align and normalize.
// Depends on sfau_pkg.
`timescale 1ns / 1ps
module sfau_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  sfau_pkg::op_t        op,
    input  logic [31:0]          a,
    input  logic [31:0]          b,
    output logic                 done,
    output logic [31:0]          res,
    output logic                 err
);
    import sfau_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ALIGN, S_MUL, S_DIV, S_NORM, S_PACK} state_t;

    state_t      state_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic        sign_reg;
    logic signed [10:0] exp_reg;
    logic [47:0] acc_reg;
    logic [23:0] mx_reg, my_reg;
    logic [7:0]  d_reg;
    logic        sub_reg, zero_reg, dz_reg, div_reg;
    logic [31:0] res_reg;
    logic        err_reg;

    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        swap;
    logic        eff_sb;
    logic [24:0] rem_sh;
    logic [25:0] rem_try;
    logic [47:0] add_try;

    assign ea = a[30:23];
    assign eb = b[30:23];
    assign ma = (ea == 8'd0) ? 24'd0 : {1'b1, a[22:0]};
    assign mb = (eb == 8'd0) ? 24'd0 : {1'b1, b[22:0]};
    assign eff_sb = b[31] ^ (op == OP_SUB);
    assign swap = (eb > ea) || ((eb == ea) && (mb > ma));
    assign rem_sh = (cnt_reg == 5'd0) ? {1'b0, mx_reg} : {mx_reg, 1'b0};
    assign rem_try = {1'b0, rem_sh} - {2'd0, my_reg};
    assign add_try = {{1'b0, acc_reg[47:24]} + (acc_reg[0] ? {1'b0, my_reg} : 25'd0),
                      acc_reg[23:1]};

    assign done = done_reg;
    assign res  = res_reg;
    assign err  = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        zero_reg <= 1'b0;
                        dz_reg   <= 1'b0;
                        div_reg  <= op == OP_DIV;
                        cnt_reg  <= 5'd0;
                        if (op == OP_ADD || op == OP_SUB) begin
                            sign_reg <= swap ? eff_sb : a[31];
                            sub_reg  <= a[31] != eff_sb;
                            exp_reg  <= swap ? {3'd0, eb} : {3'd0, ea};
                            mx_reg   <= swap ? mb : ma;
                            my_reg   <= swap ? ma : mb;
                            d_reg    <= swap ? eb - ea : ea - eb;
                            state_reg <= S_ALIGN;
                        end else if (op == OP_MUL) begin
                            sign_reg <= a[31] ^ b[31];
                            zero_reg <= (ma == 24'd0) || (mb == 24'd0);
                            exp_reg  <= $signed({3'd0, ea}) + $signed({3'd0, eb})
                                        - $signed({1'b0, EXP_BIAS});
                            acc_reg  <= {24'd0, mb};
                            my_reg   <= ma;
                            state_reg <= S_MUL;
                        end else begin
                            sign_reg <= a[31] ^ b[31];
                            zero_reg <= ma == 24'd0;
                            dz_reg   <= (ma != 24'd0) && (mb == 24'd0);
                            exp_reg  <= $signed({3'd0, ea}) - $signed({3'd0, eb})
                                        + $signed({1'b0, EXP_BIAS});
                            acc_reg  <= 48'd0;
                            mx_reg   <= ma;
                            my_reg   <= mb;
                            state_reg <= ((ma == 24'd0) || (mb == 24'd0)) ? S_PACK : S_DIV;
                        end
                    end
                end
                S_ALIGN: begin
                    // shift the smaller mantissa one bit per cycle
                    if (d_reg == 8'd0 || my_reg == 24'd0) begin
                        if (sub_reg) begin
                            acc_reg <= {24'd0, mx_reg - my_reg};
                        end else begin
                            acc_reg <= {23'd0, {1'b0, mx_reg} + {1'b0, my_reg}};
                        end
                        state_reg <= S_NORM;
                    end else begin
                        my_reg <= my_reg >> 1;
                        d_reg  <= d_reg - 8'd1;
                    end
                end
                S_MUL: begin
                    // shift-add, one multiplier bit per cycle
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd23) begin
                        acc_reg   <= add_try >> 23;
                        state_reg <= S_NORM;
                    end else begin
                        acc_reg <= add_try;
                    end
                end
                S_DIV: begin
                    // restoring step: remainder in mx_reg, quotient shifts into acc_reg
                    if (!rem_try[25]) begin
                        mx_reg  <= rem_try[23:0];
                        acc_reg <= {acc_reg[46:0], 1'b1};
                    end else begin
                        mx_reg  <= rem_sh[23:0];
                        acc_reg <= {acc_reg[46:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd24) begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (acc_reg[24:0] == 25'd0) begin
                        zero_reg  <= 1'b1;
                        state_reg <= S_PACK;
                    end else if (acc_reg[24]) begin
                        acc_reg   <= acc_reg >> 1;
                        if (!div_reg) begin
                            exp_reg <= exp_reg + 11'sd1;
                        end
                        state_reg <= S_PACK;
                    end else if (acc_reg[23]) begin
                        if (div_reg) begin
                            exp_reg <= exp_reg - 11'sd1;
                        end
                        state_reg <= S_PACK;
                    end else begin
                        acc_reg <= acc_reg << 1;
                        exp_reg <= exp_reg - 11'sd1;
                    end
                end
                S_PACK: begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    if (dz_reg) begin
                        res_reg <= {sign_reg, MAX_FINITE};
                        err_reg <= 1'b1;
                    end else if (zero_reg) begin
                        res_reg <= 32'd0;
                        err_reg <= 1'b0;
                    end else if (exp_reg > 11'sd254) begin
                        res_reg <= {sign_reg, MAX_FINITE};
                        err_reg <= 1'b1;
                    end else if (exp_reg < 11'sd1) begin
                        res_reg <= 32'd0;
                        err_reg <= 1'b1;
                    end else begin
                        res_reg <= {sign_reg, exp_reg[7:0], acc_reg[22:0]};
                        err_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/single_float_arith_unit_top.sv =====
// Top level of the single-precision arithmetic unit: stream ports and output register.
// Depends on sfau_pkg and sfau_core.
// Add/sub run longer with each alignment shift (up to 24) and each left normalize shift (up
// to 23); divide on a zero operand skips the quotient steps and goes straight to packing.
// One request is in flight at a time; the next is taken once the result has been accepted.
// Reset (aresetn low, synchronous) clears the control state and drops any held result.
`timescale 1ns / 1ps
module single_float_arith_unit_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // op
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_bits [31:0]
    output logic        m_tuser    // range_error
);
    import sfau_pkg::*;

    logic        busy_reg;
    logic        oval_reg;
    logic [31:0] odata_reg;
    logic        oerr_reg;
    logic        done;
    logic [31:0] res;
    logic        err;
    logic        start;

    assign s_tready = !busy_reg && !oval_reg;
    assign start    = s_tvalid && s_tready;

    sfau_core u_core (
        .aclk(aclk), .aresetn(aresetn), .start(start), .op(op_t'(s_tuser)),
        .a(s_tdata[31:0]), .b(s_tdata[63:32]), .done(done), .res(res), .err(err)
    );

    assign m_tvalid = oval_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = oerr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            oval_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
            if (done) begin
                oval_reg  <= 1'b1;
                odata_reg <= res;
                oerr_reg  <= err;
            end else if (oval_reg && m_tready) begin
                oval_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== design/sfau_checker.sv =====
// Port-level checker for the single-precision arithmetic unit, bound to the top level.
// Depends on sfau_pkg and single_float_arith_unit_top.
`timescale 1ns / 1ps
module sfau_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);
    import sfau_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");
    a_zero_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30:23] == 8'd0 |-> m_tdata == 32'd0)
        else $error("denormal result");
    a_err_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[30:0] == MAX_FINITE || m_tdata == 32'd0)
        else $error("range error without saturated result");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result after reset");
endmodule

bind single_float_arith_unit_top sfau_props u_sfau_props (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
